/* sv/c2e_pkg.sv */
// ----------------------------------------------------------------------------
// c2e_pkg
// Constants and calendar tables for the date to epoch-seconds converter.
// ----------------------------------------------------------------------------
`default_nettype none

package c2e_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned EpochW = 39;

  localparam logic [YearW-1:0] YearMin   = 14'd1800;
  localparam logic [YearW-1:0] YearMax   = 14'd9999;
  localparam int               EpochYear = 1970;
  // leap days in [1, 1970)
  localparam int               LeapsEpoch = 1969 / 4 - 1969 / 100 + 1969 / 400;

  // floor(a / 25) for a < 4096 by reciprocal multiply (1311 / 2^15)
  function automatic logic [7:0] div25(input logic [11:0] a);
    logic [22:0] prod;
    prod = {11'b0, a} * 23'd1311;
    return prod[22:15];
  endfunction

  // days in the months before the given month (1..12)
  function automatic logic [8:0] cum_days(input logic [MonthW-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // month length in a common year
  function automatic logic [4:0] month_len(input logic [MonthW-1:0] m);
    logic [4:0] r;
    unique case (m)
      4'd2:                      r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/calendar_to_epoch_seconds.sv */
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds
// Gregorian date and time to signed seconds since 1970-01-01 00:00:00.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with year, month, day, hour,
//   minute and second. Output channel: out_valid_o / out_stall_i with
//   valid_res_o and epoch_seconds_o. An item moves on an edge where valid is
//   high and stall is low.
//   Five register stages: range checks and divide-by-25 quotients, then the
//   day count, then days*24+h, *60+min, *60+sec. out_valid_o is the valid
//   bit of the last stage; throughput is one item per cycle while out_stall_i is low.
//   Out-of-range fields or a day past the month end give valid_res_o = 0 and
//   epoch_seconds_o = 0.
//   Reset clears all stage valid bits; the pipeline comes up empty.
//   When out_stall_i is high, the last stage holds its item and earlier
//   stages keep moving into empty slots; in_stall_o rises only once every
//   stage ahead holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_to_epoch_seconds (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [c2e_pkg::YearW-1:0]         year_i,
  input  wire logic [c2e_pkg::MonthW-1:0]        month_i,
  input  wire logic [c2e_pkg::DayW-1:0]          day_i,
  input  wire logic [c2e_pkg::HourW-1:0]         hour_i,
  input  wire logic [c2e_pkg::MinW-1:0]          minute_i,
  input  wire logic [c2e_pkg::SecW-1:0]          second_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic                              valid_res_o,
  output      logic signed [c2e_pkg::EpochW-1:0] epoch_seconds_o
);

  // stage valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------- stage 1: range checks, quotients by 100 and 400
  logic [13:0] p0;
  logic        ok1_d;
  logic [7:0]  qp100_d, qp400_d, qy100_d, qy400_d;

  logic [13:0] year1_q;
  logic [3:0]  month1_q;
  logic [4:0]  day1_q, hour1_q;
  logic [5:0]  min1_q, sec1_q;
  logic        ok1_q;
  logic [7:0]  qp100_q, qp400_q, qy100_q, qy400_q;

  always_comb begin
    p0 = year_i - 14'd1;
    ok1_d = (year_i >= c2e_pkg::YearMin) && (year_i <= c2e_pkg::YearMax)
         && (month_i >= 4'd1) && (month_i <= 4'd12)
         && (hour_i <= 5'd23) && (minute_i <= 6'd59) && (second_i <= 6'd59)
         && (day_i != 5'd0);
    // x/100 = (x>>2)/25, x/400 = (x>>4)/25
    qp100_d = c2e_pkg::div25(p0[13:2]);
    qp400_d = c2e_pkg::div25({2'b0, p0[13:4]});
    qy100_d = c2e_pkg::div25(year_i[13:2]);
    qy400_d = c2e_pkg::div25({2'b0, year_i[13:4]});
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      year1_q  <= year_i;
      month1_q <= month_i;
      day1_q   <= day_i;
      hour1_q  <= hour_i;
      min1_q   <= minute_i;
      sec1_q   <= second_i;
      ok1_q    <= ok1_d;
      qp100_q  <= qp100_d;
      qp400_q  <= qp400_d;
      qy100_q  <= qy100_d;
      qy400_q  <= qy400_d;
    end
  end

  // ---------------- stage 2: leap year, month check, day count
  logic [13:0]        p1;
  logic               leap;
  logic [4:0]         mlen;
  logic [12:0]        lb;
  logic signed [23:0] yoff;
  logic signed [23:0] days_d;
  logic               ok2_d;
  logic               ladj;

  logic signed [23:0] days2_q;
  logic [4:0]         hour2_q;
  logic [5:0]         min2_q, sec2_q;
  logic               ok2_q;

  always_comb begin
    p1 = year1_q - 14'd1;
    leap = (year1_q[1:0] == 2'b00)
        && ((year1_q[13:2] != 12'(qy100_q) * 12'd25)
         || (year1_q[13:4] == 10'(qy400_q) * 10'd25));
    mlen = c2e_pkg::month_len(month1_q);
    if ((month1_q == 4'd2) && leap) mlen = 5'd29;
    ok2_d = ok1_q && (day1_q <= mlen);
    ladj = leap && (month1_q > 4'd2);
    lb = 13'(p1[13:2]) - 13'(qp100_q) + 13'(qp400_q);
    yoff = $signed({10'b0, year1_q}) - 24'(c2e_pkg::EpochYear);
    days_d = yoff * 24'sd365
           + $signed({11'b0, lb}) - 24'(c2e_pkg::LeapsEpoch)
           + $signed({15'b0, c2e_pkg::cum_days(month1_q)})
           + $signed({23'b0, ladj})
           + $signed({19'b0, day1_q}) - 24'sd1;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      days2_q <= days_d;
      hour2_q <= hour1_q;
      min2_q  <= min1_q;
      sec2_q  <= sec1_q;
      ok2_q   <= ok2_d;
    end
  end

  // ---------------- stage 3: hours
  logic signed [28:0] dh3_q;
  logic [5:0]         min3_q, sec3_q;
  logic               ok3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      dh3_q  <= 29'(days2_q) * 29'sd24 + $signed({24'b0, hour2_q});
      min3_q <= min2_q;
      sec3_q <= sec2_q;
      ok3_q  <= ok2_q;
    end
  end

  // ---------------- stage 4: minutes
  logic signed [34:0] dm4_q;
  logic [5:0]         sec4_q;
  logic               ok4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      dm4_q  <= 35'(dh3_q) * 35'sd60 + $signed({29'b0, min3_q});
      sec4_q <= sec3_q;
      ok4_q  <= ok3_q;
    end
  end

  // ---------------- stage 5: seconds, output register
  logic signed [38:0] epoch5_d;
  logic signed [38:0] epoch5_q;
  logic               ok5_q;

  assign epoch5_d = ok4_q ? (39'(dm4_q) * 39'sd60 + $signed({33'b0, sec4_q}))
                          : 39'sd0;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      epoch5_q <= epoch5_d;
      ok5_q    <= ok4_q;
    end
  end

  assign out_valid_o     = v5_q;
  assign valid_res_o     = ok5_q;
  assign epoch_seconds_o = epoch5_q;

  // ---------------- assertions
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (epoch_seconds_o == 39'sd0))
    else $error("invalid item with nonzero epoch");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o) |->
      (epoch_seconds_o >= -39'sd5364662400 && epoch_seconds_o <= 39'sd253402300799))
    else $error("epoch out of range");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && v5_q && out_stall_i) |-> in_stall_o)
    else $error("item taken while pipeline full and stalled");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted item missing in stage 1");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !out_stall_i) |=> out_valid_o)
    else $error("stage 4 item lost");

endmodule

`default_nettype wire

/* test/tb_calendar_to_epoch_seconds.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_calendar_to_epoch_seconds
// Self-checking bench for the calendar date to epoch-seconds converter.
// Directed dates (epoch, range limits, leap rules, bad fields) are followed
// by random dates, mostly well formed, with bursty input and a receiver that
// stalls in changing patterns. A scoreboard predicts every result in order.
// ----------------------------------------------------------------------------

module tb_calendar_to_epoch_seconds;

  localparam int JAN = 1;
  localparam int FEB = 2;
  localparam int MAR = 3;
  localparam int APR = 4;
  localparam int MAY = 5;
  localparam int JUN = 6;
  localparam int SEP = 9;
  localparam int NOV = 11;
  localparam int DEC = 12;

  localparam int LastHour   = 23;
  localparam int LastMinute = 59;
  localparam int LastSecond = 59;

  localparam int RandomDates = 800;
  localparam int CycleLimit  = 300000;

  typedef logic [c2e_pkg::YearW-1:0]         year_t;
  typedef logic [c2e_pkg::MonthW-1:0]        month_t;
  typedef logic [c2e_pkg::DayW-1:0]          day_t;
  typedef logic [c2e_pkg::HourW-1:0]         hour_t;
  typedef logic [c2e_pkg::MinW-1:0]          minute_t;
  typedef logic [c2e_pkg::SecW-1:0]          second_t;
  typedef logic signed [c2e_pkg::EpochW-1:0] epoch_t;

  typedef struct packed {
    year_t   year;
    month_t  month;
    day_t    day;
    hour_t   hour;
    minute_t minute;
    second_t second;
  } stamp_t;

  typedef struct {
    stamp_t stamp;
    logic   ok;
    epoch_t secs;
  } epoch_expect_t;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
  } stall_mode_e;

  function automatic bit is_leap(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_days(int m, bit leap);
    case (m)
      FEB:                return leap ? 29 : 28;
      APR, JUN, SEP, NOV: return 30;
      default:            return 31;
    endcase
  endfunction

  // Gregorian leap days in years 1 .. y-1
  function automatic longint leap_days_before(longint y);
    longint p;
    p = y - 1;
    return p / 4 - p / 100 + p / 400;
  endfunction

  class epoch_scoreboard;
    epoch_expect_t pending_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function epoch_expect_t convert_date(stamp_t s);
      epoch_expect_t e;
      bit leap;
      longint y, days, secs;
      e.stamp = s;
      e.ok = 1'b0;
      e.secs = '0;
      y = longint'(s.year);
      if (s.year < c2e_pkg::YearMin || s.year > c2e_pkg::YearMax ||
          s.month < JAN || s.month > DEC ||
          s.day == 0 || s.hour > LastHour || s.minute > LastMinute ||
          s.second > LastSecond)
        return e;
      leap = is_leap(y);
      if (s.day > month_days(int'(s.month), leap))
        return e;
      days = 365 * (y - c2e_pkg::EpochYear) + leap_days_before(y)
             - leap_days_before(longint'(c2e_pkg::EpochYear));
      for (int m = JAN; m < s.month; m++)
        days += month_days(m, leap);
      days += longint'(s.day) - 1;
      secs = ((days * 24 + longint'(s.hour)) * 60 + longint'(s.minute)) * 60
             + longint'(s.second);
      e.ok = 1'b1;
      e.secs = secs[c2e_pkg::EpochW-1:0];
      return e;
    endfunction

    function void note_date(stamp_t s);
      pending_q.push_back(convert_date(s));
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10)
        $display("%s", msg);
    endfunction

    function void check_result(logic ok, epoch_t secs);
      epoch_expect_t e;
      if (pending_q.size() == 0) begin
        flag($sformatf("unexpected result: valid_res %0b epoch %0d", ok, secs));
        return;
      end
      e = pending_q.pop_front();
      if (ok !== e.ok)
        flag($sformatf("%0d-%0d-%0d %0d:%0d:%0d valid_res: expected %0b, got %0b",
                       e.stamp.year, e.stamp.month, e.stamp.day, e.stamp.hour,
                       e.stamp.minute, e.stamp.second, e.ok, ok));
      if (secs !== e.secs)
        flag($sformatf("%0d-%0d-%0d %0d:%0d:%0d epoch_seconds: expected %0d, got %0d",
                       e.stamp.year, e.stamp.month, e.stamp.day, e.stamp.hour,
                       e.stamp.minute, e.stamp.second, e.secs, secs));
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  year_t    year_i = '0;
  month_t   month_i = '0;
  day_t     day_i = '0;
  hour_t    hour_i = '0;
  minute_t  minute_i = '0;
  second_t  second_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  logic     valid_res_o;
  epoch_t   epoch_seconds_o;

  epoch_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  stall_mode_e     stall_mode = STALL_NONE;
  int unsigned     stall_timer = 0;

  calendar_to_epoch_seconds dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .year_i          (year_i),
    .month_i         (month_i),
    .day_i           (day_i),
    .hour_i          (hour_i),
    .minute_i        (minute_i),
    .second_i        (second_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .valid_res_o     (valid_res_o),
    .epoch_seconds_o (epoch_seconds_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: stall behavior switches at random among four patterns
  always @(posedge clk_i) begin
    if (stall_timer == 0) begin
      stall_mode  <= stall_mode_e'($urandom_range(0, 3));
      stall_timer <= $urandom_range(20, 80);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= (stall_timer[1:0] != 2'd0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(valid_res_o, epoch_seconds_o);
  end

  function automatic stamp_t make_stamp(int y, int mo, int d, int h, int mi, int s);
    stamp_t st;
    st.year   = year_t'(y);
    st.month  = month_t'(mo);
    st.day    = day_t'(d);
    st.hour   = hour_t'(h);
    st.minute = minute_t'(mi);
    st.second = second_t'(s);
    return st;
  endfunction

  function automatic int pick_year();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(c2e_pkg::YearMin, c2e_pkg::YearMax);
      1:       return $urandom_range(c2e_pkg::YearMin, c2e_pkg::YearMin + 30);
      2:       return $urandom_range(c2e_pkg::YearMax - 30, c2e_pkg::YearMax);
      3:       return 100 * $urandom_range(19, 99) + $urandom_range(0, 2) - 1;
      default: return $urandom_range(c2e_pkg::EpochYear - 12, c2e_pkg::EpochYear + 12);
    endcase
  endfunction

  function automatic stamp_t random_date();
    stamp_t s;
    int kind, lim;
    kind = $urandom_range(0, 99);
    s.year   = year_t'(pick_year());
    s.month  = month_t'($urandom_range(JAN, DEC));
    lim      = month_days(int'(s.month), is_leap(longint'(s.year)));
    s.day    = day_t'($urandom_range(1, lim));
    s.hour   = hour_t'($urandom_range(0, LastHour));
    s.minute = minute_t'($urandom_range(0, LastMinute));
    s.second = second_t'($urandom_range(0, LastSecond));
    if (kind >= 80) begin
      s = stamp_t'({$urandom, $urandom});
    end else if (kind >= 66) begin
      // one field just out of range, the rest well formed
      case ($urandom_range(0, 6))
        0: s.year   = year_t'($urandom_range(0, 1)
                              ? $urandom_range(0, c2e_pkg::YearMin - 1)
                              : $urandom_range(c2e_pkg::YearMax + 1, 16383));
        1: s.month  = month_t'($urandom_range(0, 1) ? 0 : $urandom_range(DEC + 1, 15));
        2: s.day    = '0;
        3: s.day    = day_t'((lim < 31) ? $urandom_range(lim + 1, 31) : 0);
        4: s.hour   = hour_t'($urandom_range(LastHour + 1, 31));
        5: s.minute = minute_t'($urandom_range(LastMinute + 1, 63));
        default: s.second = second_t'($urandom_range(LastSecond + 1, 63));
      endcase
    end
    return s;
  endfunction

  task automatic drive_date(stamp_t s);
    in_valid_i <= 1'b1;
    year_i     <= s.year;
    month_i    <= s.month;
    day_i      <= s.day;
    hour_i     <= s.hour;
    minute_i   <= s.minute;
    second_i   <= s.second;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_date(s);
  endtask

  task automatic idle_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    stamp_t directed_q[$];
    int burst_left;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_q.push_back(make_stamp(1970, JAN, 1, 0, 0, 0));
    directed_q.push_back(make_stamp(1969, DEC, 31, 23, 59, 59));
    directed_q.push_back(make_stamp(1800, JAN, 1, 0, 0, 0));
    directed_q.push_back(make_stamp(9999, DEC, 31, 23, 59, 59));
    directed_q.push_back(make_stamp(2000, FEB, 29, 12, 0, 0));
    directed_q.push_back(make_stamp(1900, FEB, 29, 0, 0, 0));
    directed_q.push_back(make_stamp(1900, FEB, 28, 23, 59, 59));
    directed_q.push_back(make_stamp(1800, FEB, 29, 1, 2, 3));
    directed_q.push_back(make_stamp(2024, FEB, 29, 6, 30, 0));
    directed_q.push_back(make_stamp(2023, FEB, 29, 6, 30, 0));
    directed_q.push_back(make_stamp(1804, MAR, 1, 0, 0, 1));
    directed_q.push_back(make_stamp(2023, APR, 31, 0, 0, 0));
    directed_q.push_back(make_stamp(2023, APR, 30, 0, 0, 0));
    directed_q.push_back(make_stamp(2023, JAN, 31, 0, 0, 0));
    directed_q.push_back(make_stamp(2023, JUN, 0, 0, 0, 0));
    directed_q.push_back(make_stamp(2023, 0, 10, 0, 0, 0));
    directed_q.push_back(make_stamp(2023, 13, 10, 0, 0, 0));
    directed_q.push_back(make_stamp(2023, 15, 10, 0, 0, 0));
    directed_q.push_back(make_stamp(1799, DEC, 31, 23, 59, 59));
    directed_q.push_back(make_stamp(10000, JAN, 1, 0, 0, 0));
    directed_q.push_back(make_stamp(16383, 15, 31, 31, 63, 63));
    directed_q.push_back(make_stamp(0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_stamp(2023, MAY, 5, 24, 0, 0));
    directed_q.push_back(make_stamp(2023, MAY, 5, 0, 60, 0));
    directed_q.push_back(make_stamp(2023, MAY, 5, 0, 0, 60));
    foreach (directed_q[i])
      drive_date(directed_q[i]);

    burst_left = $urandom_range(1, 30);
    for (int i = 0; i < RandomDates; i++) begin
      // hold off once mid-run until the pipeline has emptied
      if (i == RandomDates / 2)
        wait_drained();
      drive_date(random_date());
      burst_left--;
      if (burst_left == 0) begin
        idle_cycles($urandom_range(1, 12));
        burst_left = $urandom_range(1, 30);
      end
    end

    wait_drained();
    repeat (12) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
